>>> rtl/core/mnst_pkg.sv
// Shared types and constants for the MIDI note sustain tracker.
package mnst_pkg;

   localparam int ACTION_W = 3;
   localparam int NOTE_W   = 7;
   localparam int CHAN_W   = 4;
   localparam int VEL_W    = 7;
   localparam int POS_W    = 64;
   localparam int CNT_W    = 12;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NOTE_ON  = 3'd0,
      ACT_NOTE_OFF = 3'd1,
      ACT_PEDAL    = 3'd2,
      ACT_ALL_OFF  = 3'd3,
      ACT_QUERY    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LOOK,
      ST_UPDATE
   } state_type;

   // One table entry; payload fields only mean something while active is set.
   typedef struct packed {
      logic             pending;
      logic             active;
      logic             present;
      logic [VEL_W-1:0] velocity;
      logic [POS_W-1:0] start;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      logic      cnt_up;
      logic      cnt_down;
      logic      key_active;
      entry_type wr_entry;
   } upd_type;

endpackage

>>> rtl/core/mnst_if.sv
// Request and response channel interfaces for the note sustain tracker.
interface mnst_req_if;
   import mnst_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [NOTE_W-1:0]   note_number;
   logic [CHAN_W-1:0]   channel_number;
   logic [VEL_W-1:0]    strike_velocity;
   logic [POS_W-1:0]    sample_position;
   logic                pedal_is_down;

   modport source (
      output valid, action, note_number, channel_number, strike_velocity,
             sample_position, pedal_is_down,
      input  ready
   );
   modport sink (
      input  valid, action, note_number, channel_number, strike_velocity,
             sample_position, pedal_is_down,
      output ready
   );
endinterface

interface mnst_rsp_if;
   import mnst_pkg::*;

   logic             valid;
   logic             ready;
   logic             key_active;
   logic [VEL_W-1:0] key_velocity;
   logic [POS_W-1:0] key_start;
   logic [CNT_W-1:0] active_total;

   modport source (
      output valid, key_active, key_velocity, key_start, active_total,
      input  ready
   );
   modport sink (
      input  valid, key_active, key_velocity, key_start, active_total,
      output ready
   );
endinterface

>>> rtl/core/mnst_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module mnst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mnst_update.sv
// Read-modify-write step for one addressed table entry.
module mnst_update (
   input  logic                            key_ok,
   input  logic [mnst_pkg::ACTION_W-1:0]   act,
   input  logic                            pedal_held,
   input  logic [mnst_pkg::VEL_W-1:0]      vel,
   input  logic [mnst_pkg::POS_W-1:0]      pos,
   input  mnst_pkg::entry_type             rd_entry,
   output mnst_pkg::upd_type               upd
);
   import mnst_pkg::*;

   entry_type nxt;

   always_comb begin
      nxt = rd_entry;
      upd = '0;
      case (act)
         ACT_NOTE_ON: begin
            if (key_ok) begin
               // pending is left alone: a later pedal release erases the note
               nxt.present  = 1'b1;
               nxt.active   = 1'b1;
               nxt.velocity = vel;
               nxt.start    = pos;
               upd.wr_en    = 1'b1;
               upd.cnt_up   = !rd_entry.active;
            end
         end
         ACT_NOTE_OFF: begin
            if (key_ok && rd_entry.present) begin
               upd.wr_en    = 1'b1;
               upd.cnt_down = rd_entry.active;
               nxt.active   = 1'b0;
               if (pedal_held) begin
                  nxt.pending = 1'b1;
               end else begin
                  nxt.pending = 1'b0;
                  nxt.present = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      upd.wr_entry   = nxt;
      upd.key_active = key_ok && nxt.present && nxt.active;
   end

endmodule

>>> rtl/core/midi_note_sustain_tracker.sv
// Note sustain tracker: one table entry per note and channel in a single RAM.
// An item is taken, its entry is read and written back, and the result lands in an output
// register. A pedal release and an all-off walk the whole table through the RAM, one entry
// per cycle. After reset a clearing pass runs with req_chan.ready low.
// A finished result may wait in the output register while the next item is taken.
module midi_note_sustain_tracker #(
   parameter int NOTE_COUNT    = 128,
   parameter int CHANNEL_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   mnst_req_if.sink   req_chan,
   mnst_rsp_if.source rsp_chan
);
   import mnst_pkg::*;

   localparam int DEPTH = NOTE_COUNT * CHANNEL_COUNT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = AW + 1;
   localparam int EW    = $bits(entry_type);

   state_type state_ff, state_in;

   logic [CW-1:0]       idx_ff, idx_in;
   logic                sweep_clear_ff, sweep_clear_in;
   logic                sweep_init_ff, sweep_init_in;
   logic                stg_vld_ff, stg_vld_in;
   logic [AW-1:0]       stg_addr_ff, stg_addr_in;
   logic                pedal_held_ff, pedal_held_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [AW-1:0]       key_addr_ff, key_addr_in;
   logic                key_ok_ff, key_ok_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [VEL_W-1:0]    vel_ff, vel_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_active_ff, rsp_active_in;
   logic [VEL_W-1:0]    rsp_vel_ff, rsp_vel_in;
   logic [POS_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [CNT_W-1:0]    rsp_total_ff, rsp_total_in;

   logic                accept;
   logic                advance;
   logic                need_sweep;
   logic                req_ok;
   logic [AW-1:0]       req_addr;
   logic                sweep_erase;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [AW-1:0]       ram_raddr;
   entry_type           ram_wdata;
   entry_type           ram_rdata;
   upd_type             upd;

   // Request decode
   assign req_ok = ({1'b0, req_chan.note_number} < (NOTE_W + 1)'(NOTE_COUNT)) &&
                   ({1'b0, req_chan.channel_number} < (CHAN_W + 1)'(CHANNEL_COUNT));
   assign req_addr = AW'(req_chan.note_number) * AW'(CHANNEL_COUNT) +
                     AW'(req_chan.channel_number);
   assign need_sweep = (req_chan.action == ACT_ALL_OFF) ||
                       ((req_chan.action == ACT_PEDAL) && !req_chan.pedal_is_down);
   assign accept  = req_chan.valid && req_chan.ready;
   assign advance = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_chan.ready);
   assign sweep_erase = stg_vld_ff && ram_rdata.pending;

   mnst_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mnst_update u_update (
      .key_ok     (key_ok_ff),
      .act        (act_ff),
      .pedal_held (pedal_held_ff),
      .vel        (vel_ff),
      .pos        (pos_ff),
      .rd_entry   (ram_rdata),
      .upd        (upd)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = need_sweep ? ST_SWEEP : ST_UPDATE;
            end
         end
         ST_SWEEP: begin
            if (idx_ff == CW'(DEPTH)) begin
               state_in = sweep_init_ff ? ST_IDLE : ST_LOOK;
            end
         end
         ST_LOOK:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // RAM port control and handshake outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      ram_we    = 1'b0;
      ram_waddr = key_addr_ff;
      ram_wdata = upd.wr_entry;
      ram_raddr = key_addr_ff;
      case (state_ff)
         ST_IDLE:   ram_raddr = req_addr;
         ST_SWEEP: begin
            ram_raddr = idx_ff[AW-1:0];
            ram_wdata = '0;
            if (sweep_clear_ff) begin
               ram_we    = (idx_ff != CW'(DEPTH));
               ram_waddr = idx_ff[AW-1:0];
            end else begin
               // the entry read last cycle is written back erased if pending
               ram_we    = sweep_erase;
               ram_waddr = stg_addr_ff;
            end
         end
         ST_LOOK:   ram_raddr = key_addr_ff;
         ST_UPDATE: ram_we = upd.wr_en && advance;
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      idx_in         = idx_ff;
      sweep_clear_in = sweep_clear_ff;
      sweep_init_in  = sweep_init_ff;
      stg_vld_in     = 1'b0;
      stg_addr_in    = idx_ff[AW-1:0];
      pedal_held_in  = pedal_held_ff;
      cnt_in         = cnt_ff;
      key_addr_in    = key_addr_ff;
      key_ok_in      = key_ok_ff;
      act_in         = act_ff;
      vel_in         = vel_ff;
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_active_in  = rsp_active_ff;
      rsp_vel_in     = rsp_vel_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_total_in   = rsp_total_ff;

      if (accept) begin
         key_addr_in    = req_ok ? req_addr : '0;
         key_ok_in      = req_ok;
         act_in         = req_chan.action;
         vel_in         = req_chan.strike_velocity;
         pos_in         = req_chan.sample_position;
         idx_in         = '0;
         sweep_clear_in = (req_chan.action == ACT_ALL_OFF);
         if (req_chan.action == ACT_PEDAL) begin
            pedal_held_in = req_chan.pedal_is_down;
         end
         if (req_chan.action == ACT_ALL_OFF) begin
            cnt_in = '0;
         end
      end

      if (state_ff == ST_SWEEP) begin
         if (idx_ff != CW'(DEPTH)) begin
            idx_in     = idx_ff + CW'(1);
            stg_vld_in = !sweep_clear_ff;
         end else begin
            sweep_init_in = 1'b0;
         end
         if (!sweep_clear_ff && sweep_erase && ram_rdata.active) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end

      if (advance) begin
         cnt_in        = cnt_ff + CNT_W'(upd.cnt_up) - CNT_W'(upd.cnt_down);
         rsp_valid_in  = 1'b1;
         rsp_active_in = upd.key_active;
         rsp_vel_in    = upd.key_active ? upd.wr_entry.velocity : '0;
         rsp_start_in  = upd.key_active ? upd.wr_entry.start : '0;
         rsp_total_in  = cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         idx_ff         <= '0;
         sweep_clear_ff <= 1'b1;
         sweep_init_ff  <= 1'b1;
         stg_vld_ff     <= 1'b0;
         pedal_held_ff  <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         sweep_clear_ff <= sweep_clear_in;
         sweep_init_ff  <= sweep_init_in;
         stg_vld_ff     <= stg_vld_in;
         pedal_held_ff  <= pedal_held_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      stg_addr_ff   <= stg_addr_in;
      key_addr_ff   <= key_addr_in;
      key_ok_ff     <= key_ok_in;
      act_ff        <= act_in;
      vel_ff        <= vel_in;
      pos_ff        <= pos_in;
      rsp_active_ff <= rsp_active_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.key_active   = rsp_active_ff;
   assign rsp_chan.key_velocity = rsp_vel_ff;
   assign rsp_chan.key_start    = rsp_start_ff;
   assign rsp_chan.active_total = rsp_total_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("active count exceeds table depth");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result appeared without an entry update");

   a_stage_in_release: assert property (@(posedge clock) disable iff (reset)
      stg_vld_ff |-> (state_ff == ST_SWEEP) && !sweep_clear_ff)
      else $error("release stage active outside a release sweep");

   a_all_off_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.action == ACT_ALL_OFF)) |=> (cnt_ff == '0))
      else $error("active count not cleared by all-off");

endmodule
